// File: hw/rtl/mch_pkg.sv
// Shared types, constants and helper functions for the magnetometer heading block.
package mch_pkg;

   // One raw magnetometer sample: low byte first for each axis.
   typedef struct packed {
      logic [7:0] x_low_byte;
      logic [7:0] x_high_byte;
      logic [7:0] y_low_byte;
      logic [7:0] y_high_byte;
      logic [7:0] z_low_byte;
      logic [7:0] z_high_byte;
   } req_type;

   // One calibrated sample with its compass heading.
   typedef struct packed {
      logic signed [15:0] cal_x;
      logic signed [15:0] cal_y;
      logic signed [15:0] cal_z;
      logic [16:0]        heading;
   } rsp_type;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FUSE_X = 2'd0,
      CSR_FUSE_Y = 2'd1,
      CSR_FUSE_Z = 2'd2
   } csr_index_type;

   localparam logic [7:0] FUSE_RESET = 8'd128;

   // Heading codes in 1/256 degree units.
   localparam logic [16:0] HEAD_090 = 17'd23040;
   localparam logic [16:0] HEAD_180 = 17'd46080;
   localparam logic [16:0] HEAD_270 = 17'd69120;
   localparam logic [16:0] HEAD_360 = 17'd92160;

   // Internal angle width (2^-16 degree units, signed) and vector width.
   localparam int ZW = 26;
   localparam int XW = 35;
   localparam logic signed [ZW-1:0] Z_180 = 26'sd11796480;
   localparam logic signed [ZW-1:0] Z_360 = 26'sd23592960;

   // Arctangent of 2^-i in 2^-16 degree units.
   localparam int ATAN_ENTRIES = 24;
   localparam logic [21:0] ATAN_TAB [ATAN_ENTRIES] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
      22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
      22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
   };

   // Stages in front of and behind the rotation stages.
   localparam int CAL_STAGES  = 2;
   localparam int HEAD_EXTRA  = 3;

   // Number of rotation stages actually built.
   function automatic int cordic_iters(input int steps);
      return (steps > ATAN_ENTRIES) ? ATAN_ENTRIES : steps;
   endfunction

   // Cycles from an accepted beat to its result strobe.
   function automatic int pipe_latency(input int steps);
      return CAL_STAGES + HEAD_EXTRA + cordic_iters(steps);
   endfunction

endpackage

// File: hw/rtl/magnetometer_calibrate_heading.sv
// Top level: per-axis sensitivity adjustment and compass heading of a magnetometer sample.
// Throughput: one beat per cycle; busy stays low, the pipeline of one rotation
// per stage takes a new sample every cycle and the receiver cannot stall it.
// Reset: synchronous; clears all valid bits and sets each fuse register to 128.
module magnetometer_calibrate_heading import mch_pkg::*; #(
   parameter int ANGLE_STEPS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_strobe,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   localparam int DLY = cordic_iters(ANGLE_STEPS) + HEAD_EXTRA;

   logic [7:0] fuse_ff [3];

   // Fuse registers; writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         fuse_ff[0] <= FUSE_RESET;
         fuse_ff[1] <= FUSE_RESET;
         fuse_ff[2] <= FUSE_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FUSE_X: fuse_ff[0] <= csr_data;
            CSR_FUSE_Y: fuse_ff[1] <= csr_data;
            CSR_FUSE_Z: fuse_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   logic signed [15:0] raw   [3];
   logic signed [25:0] prod_in [3];
   logic signed [25:0] prod_ff [3];
   logic               prod_vld_ff;

   // Join the bytes of each axis and multiply by its gain (fuse + 128).
   assign raw[0] = {req_data.x_high_byte, req_data.x_low_byte};
   assign raw[1] = {req_data.y_high_byte, req_data.y_low_byte};
   assign raw[2] = {req_data.z_high_byte, req_data.z_low_byte};

   for (genvar a = 0; a < 3; a++) begin : g_mul
      logic signed [9:0] gain;
      assign gain       = signed'({2'b00, fuse_ff[a]} + 10'd128);
      assign prod_in[a] = raw[a] * gain;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= start & ~busy;
      end
      prod_ff <= prod_in;
   end

   logic signed [15:0] cal_in [3];
   logic signed [15:0] cal_ff [3];
   logic               cal_vld_ff;

   // Divide by 256 toward zero, then saturate to 16 bits.
   for (genvar a = 0; a < 3; a++) begin : g_sat
      logic signed [25:0] adj;
      logic signed [17:0] quo;
      assign adj = prod_ff[a] + (prod_ff[a][25] ? 26'sd255 : 26'sd0);
      assign quo = adj[25:8];
      always_comb begin
         if (quo > 18'sd32767) begin
            cal_in[a] = 16'sh7fff;
         end else if (quo < -18'sd32768) begin
            cal_in[a] = 16'sh8000;
         end else begin
            cal_in[a] = quo[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_vld_ff <= 1'b0;
      end else begin
         cal_vld_ff <= prod_vld_ff;
      end
      cal_ff <= cal_in;
   end

   // Heading pipeline.
   logic        head_vld;
   logic [16:0] head;

   mch_cordic #(
      .ANGLE_STEPS(ANGLE_STEPS)
   ) u_cordic (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (cal_vld_ff),
      .in_x        (cal_ff[0]),
      .in_y        (cal_ff[1]),
      .out_valid   (head_vld),
      .out_heading (head)
   );

   // Calibrated values wait alongside the heading pipeline.
   logic [47:0] dly_ff [DLY];

   always_ff @(posedge clock) begin
      dly_ff[0] <= {cal_ff[0], cal_ff[1], cal_ff[2]};
      for (int k = 1; k < DLY; k++) begin
         dly_ff[k] <= dly_ff[k-1];
      end
   end

   assign rsp_strobe       = head_vld;
   assign rsp_data.cal_x   = dly_ff[DLY-1][47:32];
   assign rsp_data.cal_y   = dly_ff[DLY-1][31:16];
   assign rsp_data.cal_z   = dly_ff[DLY-1][15:0];
   assign rsp_data.heading = head;

endmodule

// File: hw/rtl/mch_cordic.sv
// Pipelined vectoring CORDIC that turns calibrated x and y into a compass heading.
module mch_cordic import mch_pkg::*; #(
   parameter int ANGLE_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [15:0] in_x,
   input  logic signed [15:0] in_y,
   output logic               out_valid,
   output logic [16:0]        out_heading
);

   localparam int ITER = cordic_iters(ANGLE_STEPS);

   // Axis cases that bypass the rotation.
   typedef enum logic [2:0] {
      SPC_NONE,
      SPC_EAST,
      SPC_WEST,
      SPC_NORTH,
      SPC_SOUTH
   } spc_type;

   logic                 vld_ff [ITER+1];
   logic signed [XW-1:0] x_ff   [ITER+1];
   logic signed [XW-1:0] y_ff   [ITER+1];
   logic signed [ZW-1:0] z_ff   [ITER+1];
   spc_type              spc_ff [ITER+1];

   logic signed [XW-1:0] x_in;
   logic signed [XW-1:0] y_in;
   logic signed [ZW-1:0] z_in;
   spc_type              spc_in;

   // Prepare: scale by 2^16, fold the left half plane into the right one,
   // and seed the angle with the base angle plus 180 degrees.
   always_comb begin
      x_in = {{(XW-32){in_x[15]}}, in_x, 16'h0000};
      y_in = {{(XW-32){in_y[15]}}, in_y, 16'h0000};
      z_in = Z_180;
      if (in_x[15]) begin
         x_in = -x_in;
         y_in = -y_in;
         z_in = in_y[15] ? '0 : Z_360;
      end
      if (in_y == 16'sd0) begin
         spc_in = in_x[15] ? SPC_WEST : SPC_EAST;
      end else if (in_x == 16'sd0) begin
         spc_in = in_y[15] ? SPC_SOUTH : SPC_NORTH;
      end else begin
         spc_in = SPC_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
      x_ff[0]   <= x_in;
      y_ff[0]   <= y_in;
      z_ff[0]   <= z_in;
      spc_ff[0] <= spc_in;
   end

   // One rotation per stage; shifts floor toward minus infinity.
   for (genvar i = 0; i < ITER; i++) begin : g_rot
      localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[i]);
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (y_ff[i] > 0) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + ANG;
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - ANG;
         end
         spc_ff[i+1] <= spc_ff[i];
      end
   end

   logic        clp_vld_ff;
   logic [24:0] clp_t_ff;
   spc_type     clp_spc_ff;
   logic        out_vld_ff;
   logic [16:0] out_head_ff;
   logic [25:0] rnd_sum;

   // Clamp the angle to the 0 to 360 degree range.
   always_ff @(posedge clock) begin
      if (reset) begin
         clp_vld_ff <= 1'b0;
      end else begin
         clp_vld_ff <= vld_ff[ITER];
      end
      if (z_ff[ITER] < 0) begin
         clp_t_ff <= '0;
      end else if (z_ff[ITER] > Z_360) begin
         clp_t_ff <= Z_360[24:0];
      end else begin
         clp_t_ff <= z_ff[ITER][24:0];
      end
      clp_spc_ff <= spc_ff[ITER];
   end

   // Round to 1/256 degree, or take the fixed heading of an axis case.
   assign rnd_sum = {1'b0, clp_t_ff} + 26'd128;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= clp_vld_ff;
      end
      unique case (clp_spc_ff)
         SPC_EAST:  out_head_ff <= HEAD_180;
         SPC_WEST:  out_head_ff <= HEAD_360;
         SPC_NORTH: out_head_ff <= HEAD_270;
         SPC_SOUTH: out_head_ff <= HEAD_090;
         default:   out_head_ff <= rnd_sum[24:8];
      endcase
   end

   assign out_valid   = out_vld_ff;
   assign out_heading = out_head_ff;

endmodule

// File: hw/rtl/mch_checker.sv
// Port-level checker for the magnetometer heading block, with its bind.
module mch_checker import mch_pkg::*; #(
   parameter int ANGLE_STEPS = 16
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   localparam int LAT = pipe_latency(ANGLE_STEPS);

   // Reset empties the pipeline.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result beat right after reset");

   // Every result beat comes from a beat accepted a fixed latency earlier.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result beat without a matching accepted beat");

   // Heading never passes 360 degrees.
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_data.heading <= HEAD_360)
      else $error("heading out of range");

   // On the x axis the heading is fixed.
   a_x_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.cal_y == 16'sd0 |->
         rsp_data.heading == (rsp_data.cal_x[15] ? HEAD_360 : HEAD_180))
      else $error("wrong heading on the x axis");

   // On the y axis the heading is fixed.
   a_y_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.cal_x == 16'sd0 && rsp_data.cal_y != 16'sd0 |->
         rsp_data.heading == (rsp_data.cal_y[15] ? HEAD_090 : HEAD_270))
      else $error("wrong heading on the y axis");

endmodule

bind magnetometer_calibrate_heading mch_checker #(
   .ANGLE_STEPS(ANGLE_STEPS)
) u_mch_checker (.*);

// File: dv/magnetometer_calibrate_heading_tb.sv
// Self-checking testbench for the magnetometer calibration and heading block.
module magnetometer_calibrate_heading_tb;
   import mch_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_STEPS = 16;
   localparam int ROT_STEPS   = (ANGLE_STEPS > 24) ? 24 : ANGLE_STEPS;
   localparam int PIPE_CYCLES = ROT_STEPS + 5;
   localparam longint DEG_UNIT = 65536;
   localparam int OUT_UNIT     = 256;
   localparam int RANDOM_ITEMS = 570;

   // Register index the block does not decode.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // Arctangent of 2^-i in 2^-16 degree units.
   localparam longint ATAN_DEG [0:23] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0
   };

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_data;

   // Testbench copy of the fuse registers and the calibrated samples in flight.
   logic [7:0] fuse_model [3];
   rsp_type    calibrated_q [$];
   int         mismatch_count;
   bit         no_idle;

   magnetometer_calibrate_heading #(
      .ANGLE_STEPS(ANGLE_STEPS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #2ms;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Gain (fuse+128)/256, truncated toward zero, saturated to 16 bits.
   function automatic logic signed [15:0] scale_axis(input logic [15:0] word,
                                                     input logic [7:0] fuse);
      int raw;
      int prod;
      int q;
      raw  = int'($signed(word));
      prod = raw * (int'(fuse) + 128);
      q    = prod / 256;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return 16'(q);
   endfunction

   // Vectoring rotation of (x, y) toward the x axis; heading is atan2 plus 180 degrees.
   function automatic logic [16:0] compass_heading(input int cx, input int cy);
      longint vx, vy, xs, ys, ang, base, t;
      int     n;
      if (cy == 0) return (cx < 0) ? 17'(360 * OUT_UNIT) : 17'(180 * OUT_UNIT);
      if (cx == 0) return (cy > 0) ? 17'(270 * OUT_UNIT) : 17'(90 * OUT_UNIT);
      ang  = 0;
      base = 0;
      vx   = longint'(cx) * DEG_UNIT;
      vy   = longint'(cy) * DEG_UNIT;
      // Left half plane: mirror into the right half and remember half a turn.
      if (cx < 0) begin
         vx   = -vx;
         vy   = -vy;
         base = (cy >= 0) ? 180 * DEG_UNIT : -180 * DEG_UNIT;
      end
      for (n = 0; n < ROT_STEPS; n++) begin
         xs = vx >>> n;
         ys = vy >>> n;
         if (vy > 0) begin
            vx  = vx + ys;
            vy  = vy - xs;
            ang = ang + ATAN_DEG[n];
         end else begin
            vx  = vx - ys;
            vy  = vy + xs;
            ang = ang - ATAN_DEG[n];
         end
      end
      t = base + ang + 180 * DEG_UNIT;
      if (t < 0) t = 0;
      if (t > 360 * DEG_UNIT) t = 360 * DEG_UNIT;
      t = (t + 128) >>> 8;
      return t[16:0];
   endfunction

   function automatic rsp_type calibrate_sample(input req_type s);
      rsp_type r;
      r.cal_x   = scale_axis({s.x_high_byte, s.x_low_byte}, fuse_model[CSR_FUSE_X]);
      r.cal_y   = scale_axis({s.y_high_byte, s.y_low_byte}, fuse_model[CSR_FUSE_Y]);
      r.cal_z   = scale_axis({s.z_high_byte, s.z_low_byte}, fuse_model[CSR_FUSE_Z]);
      r.heading = compass_heading(int'(r.cal_x), int'(r.cal_y));
      return r;
   endfunction

   function automatic req_type pack_sample(input logic [15:0] x, input logic [15:0] y,
                                           input logic [15:0] z);
      req_type s;
      s.x_low_byte  = x[7:0];
      s.x_high_byte = x[15:8];
      s.y_low_byte  = y[7:0];
      s.y_high_byte = y[15:8];
      s.z_low_byte  = z[7:0];
      s.z_high_byte = z[15:8];
      return s;
   endfunction

   // Axis reading weighted toward the extremes, zero and tiny values.
   function automatic logic [15:0] pick_axis();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'($urandom_range(0, 16)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] pick_fuse();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly back to back or short gaps, now and then a long one.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Offer one beat, wait for acceptance, then idle for a random gap.
   task automatic send_sample(input req_type s);
      int gap;
      start    <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (busy !== 1'b0);
      calibrated_q.push_back(calibrate_sample(s));
      gap = idle_cycles();
      if (gap > 0) begin
         start    <= 1'b0;
         req_data <= req_type'({$urandom, $urandom});
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering beats and wait until every calibrated sample has come back.
   task automatic drain_pipeline();
      start <= 1'b0;
      do @(posedge clock); while (calibrated_q.size() != 0);
   endtask

   task automatic write_fuse(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx <= CSR_FUSE_Z) fuse_model[idx] = val;
      csr_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clock);
   endtask

   task automatic write_all_fuses(input logic [7:0] fx, input logic [7:0] fy,
                                  input logic [7:0] fz);
      write_fuse(CSR_FUSE_X, fx);
      write_fuse(CSR_FUSE_Y, fy);
      write_fuse(CSR_FUSE_Z, fz);
   endtask

   // Axis directions, zero vector and full-scale readings at the reset gain of one.
   task automatic test_reset_gain();
      send_sample(pack_sample(16'h0000, 16'h0000, 16'h0000));
      send_sample(pack_sample(16'd100, 16'h0000, 16'd7));
      send_sample(pack_sample(16'(-100), 16'h0000, 16'd0));
      send_sample(pack_sample(16'h0000, 16'd100, 16'd0));
      send_sample(pack_sample(16'h0000, 16'(-100), 16'd0));
      send_sample(pack_sample(16'h7FFF, 16'h7FFF, 16'h7FFF));
      send_sample(pack_sample(16'h8000, 16'h8000, 16'h8000));
      send_sample(pack_sample(16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_sample(pack_sample(16'd1, 16'hFFFF, 16'h0001));
      send_sample(pack_sample(16'hFFFF, 16'd1, 16'h8000));
      send_sample(pack_sample(16'h8000, 16'd1, 16'h7FFF));
      send_sample(pack_sample(16'h8000, 16'hFFFF, 16'h0000));
      send_sample(pack_sample(16'hA55A, 16'h5AA5, 16'h5AA5));
      drain_pipeline();
   endtask

   // Largest gain drives the products past the 16-bit range; the unused index is ignored.
   task automatic test_saturation();
      write_all_fuses(8'd255, 8'd255, 8'd255);
      write_fuse(CSR_UNUSED, 8'd0);
      send_sample(pack_sample(16'h7FFF, 16'h8000, 16'h7FFF));
      send_sample(pack_sample(16'h8000, 16'h7FFF, 16'h8000));
      send_sample(pack_sample(16'h4000, 16'hC000, 16'h5555));
      send_sample(pack_sample(16'hC000, 16'h4000, 16'hAAAA));
      drain_pipeline();
   endtask

   // Half gain: odd readings truncate toward zero, tiny y collapses onto the x axis.
   task automatic test_half_gain();
      write_all_fuses(8'd0, 8'd0, 8'd0);
      send_sample(pack_sample(16'hFFFF, 16'd1, 16'hFFFF));
      send_sample(pack_sample(16'd1, 16'hFFFF, 16'd1));
      send_sample(pack_sample(16'h7FFF, 16'h8000, 16'h8000));
      send_sample(pack_sample(16'(-3), 16'd1, 16'd3));
      send_sample(pack_sample(16'd3, 16'hFFFF, 16'h7FFF));
      drain_pipeline();
   endtask

   // Mixed per-axis gains, each setting followed by a batch of random samples.
   task automatic test_gain_sweep();
      int k, m;
      for (k = 0; k < 4; k++) begin
         case (k)
            0: write_all_fuses(8'd0, 8'd255, 8'd128);
            1: write_all_fuses(8'd255, 8'd0, 8'd1);
            default: write_all_fuses(pick_fuse(), pick_fuse(), pick_fuse());
         endcase
         for (m = 0; m < 40; m++) send_sample(pack_sample(pick_axis(), pick_axis(), pick_axis()));
         drain_pipeline();
      end
   endtask

   // Long random run with gain changes between bursts and stretches without gaps.
   task automatic test_random_traffic();
      int k;
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 150 == 0 && k > 0) begin
            drain_pipeline();
            write_all_fuses(pick_fuse(), pick_fuse(), pick_fuse());
         end
         if (k % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
         send_sample(pack_sample(pick_axis(), pick_axis(), pick_axis()));
      end
      no_idle = 1'b0;
      drain_pipeline();
   endtask

   // Compare each result beat with the oldest calibrated sample in flight.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (calibrated_q.size() == 0) begin
            report_mismatch("result beat with no sample in flight");
         end else begin
            want = calibrated_q.pop_front();
            if (rsp_data.cal_x !== want.cal_x)
               report_mismatch($sformatf("cal_x got %0d want %0d",
                                         rsp_data.cal_x, want.cal_x));
            if (rsp_data.cal_y !== want.cal_y)
               report_mismatch($sformatf("cal_y got %0d want %0d",
                                         rsp_data.cal_y, want.cal_y));
            if (rsp_data.cal_z !== want.cal_z)
               report_mismatch($sformatf("cal_z got %0d want %0d",
                                         rsp_data.cal_z, want.cal_z));
            if (rsp_data.heading !== want.heading)
               report_mismatch($sformatf("heading got %0d want %0d (x %0d y %0d)",
                                         rsp_data.heading, want.heading,
                                         want.cal_x, want.cal_y));
         end
      end
   end

   initial begin
      mismatch_count = 0;
      no_idle        = 1'b0;
      fuse_model[0]  = 8'd128;
      fuse_model[1]  = 8'd128;
      fuse_model[2]  = 8'd128;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_FUSE_X;
      csr_data  <= 8'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_gain();
      test_saturation();
      test_half_gain();
      test_gain_sweep();
      test_random_traffic();

      // Let any stray beat show up before the verdict.
      repeat (PIPE_CYCLES + 10) @(posedge clock);
      if (calibrated_q.size() != 0)
         report_mismatch($sformatf("%0d samples never came back", calibrated_q.size()));
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
